// ===== design/sva_pkg.sv =====
`default_nettype none
package sva_pkg;
    localparam int unsigned OpW = 2;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ADVANCE  = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_CACHE_READY  = 3'd0,
        CFG_LOWEST_ROOT  = 3'd1,
        CFG_HIGHEST_ROOT = 3'd2,
        CFG_ROOT_SPACING = 3'd3,
        CFG_RELEASE_LEN  = 3'd4,
        CFG_SAMPLE_LEN   = 3'd5
    } t_cfg_idx;

    localparam logic [23:0] PosMax = 24'hFFFFFF;
    localparam logic [23:0] EndGuard = 24'd5;

    function automatic logic [14:0] pitch_lookup(input logic [3:0] idx);
        logic [14:0] r;
        begin
            case (idx)
                4'd0:    r = 15'd11585;
                4'd1:    r = 15'd12274;
                4'd2:    r = 15'd13004;
                4'd3:    r = 15'd13777;
                4'd4:    r = 15'd14596;
                4'd5:    r = 15'd15464;
                4'd6:    r = 15'd16384;
                4'd7:    r = 15'd17358;
                4'd8:    r = 15'd18390;
                4'd9:    r = 15'd19484;
                4'd10:   r = 15'd20643;
                4'd11:   r = 15'd21870;
                4'd12:   r = 15'd23170;
                default: r = 15'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== design/sva_ram.sv =====
`default_nettype none
module sva_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [AW-1:0]     i_waddr,
    input  wire [WIDTH-1:0]  i_wdata,
    input  wire [AW-1:0]     i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/sampler_voice_allocator.sv =====
// Voice allocator for a sample player.
// Path to m_axis_tvalid: advance S_ARD, S_AWR, S_OUT; note-off S_SCAN, S_PICK, S_OUT;
// note-on S_ROOT, S_SCAN, S_PICK, S_OUT, or only S_OUT while the cache is not ready;
// others S_OUT. One item in flight; the next item is taken the cycle after the result
// register loads. The grid walk (one root per cycle) and the voice scan set the time.
// Reset (sync, active low) clears control state and the active/releasing/written flags.
`default_nettype none
module sampler_voice_allocator
    import sva_pkg::*;
#(
    parameter int unsigned VOICES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // tdata: op[1:0], key[8:2], voice_sel[12:9], consumed[28:13], block_len[41:29]
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,
    // tdata: accepted[0], chosen_voice[4:1], was_stolen[5], root_note[12:6],
    // pitch_ratio[27:13], released_mask[43:28], voice_live[44], fade_left[60:45]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [23:0] i_cfg_data
);
    localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int unsigned CW = $clog2(VOICES + 1);
    // memory word: key, root, position, fade
    localparam int unsigned MW = 7 + 7 + 24 + 16;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ROOT  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_ARD   = 7'b0010000,
        S_AWR   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // config
    logic        r_cache_ready;
    logic [6:0]  r_lowest, r_highest;
    logic [3:0]  r_spacing;
    logic [15:0] r_release_len;
    logic [23:0] r_sample_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_ready <= 1'b0;
            r_lowest      <= 7'd24;
            r_highest     <= 7'd84;
            r_spacing     <= 4'd6;
            r_release_len <= 16'd4800;
            r_sample_len  <= 24'd64000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CACHE_READY:  r_cache_ready <= i_cfg_data[0];
                CFG_LOWEST_ROOT:  r_lowest      <= i_cfg_data[6:0];
                CFG_HIGHEST_ROOT: r_highest     <= i_cfg_data[6:0];
                CFG_ROOT_SPACING: r_spacing     <= i_cfg_data[3:0];
                CFG_RELEASE_LEN:  r_release_len <= i_cfg_data[15:0];
                CFG_SAMPLE_LEN:   r_sample_len  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // flags in flip-flops, voice data in memory
    // r_written marks entries loaded by a note-on; for others an advance reads the fade as zero
    logic [VOICES-1:0] r_active, r_releasing, r_written;

    t_state      r_state;
    t_op         r_op;
    logic [6:0]  r_key;
    logic [3:0]  r_sel;
    logic [15:0] r_consumed;
    logic [12:0] r_block_len;
    logic [CW-1:0] r_cnt;          // scan read address counter
    logic [CW-1:0] r_cmp;          // one above the index of data now on read port
    logic [7:0]  r_lower;          // grid walker
    logic [6:0]  r_root;
    logic [VW-1:0] r_pick;
    logic [23:0] r_best_pos;
    logic        r_stolen;
    logic [VOICES-1:0] r_mask;
    logic [63:0] r_res;            // result being built
    logic [63:0] r_out;            // output register
    logic        r_out_valid;

    logic          mem_we;
    logic [VW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata, mem_rdata;

    sva_ram #(.WIDTH(MW), .DEPTH(VOICES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic [6:0]  rd_key;
    logic [23:0] rd_pos;
    logic [15:0] rd_fade;
    assign rd_key  = mem_rdata[53:47];
    assign rd_pos  = mem_rdata[39:16];
    assign rd_fade = mem_rdata[15:0];

    logic [3:0] sp;
    assign sp = (r_spacing == 4'd0) ? 4'd1 : r_spacing;

    // grid walk: r_lower steps up by sp while next root is a grid point <= key and <= cap
    logic [7:0] nxt;
    logic [7:0] cap;
    logic       step_ok;
    assign nxt = r_lower + {4'd0, sp};
    assign cap = (r_highest > r_lowest) ? {1'b0, r_highest} : {1'b0, r_lowest};
    assign step_ok = (nxt <= {1'b0, r_key}) && (nxt <= cap);

    // first idle voice
    logic          any_idle;
    logic [VW-1:0] first_idle;
    always_comb begin
        any_idle   = 1'b0;
        first_idle = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                any_idle   = 1'b1;
                first_idle = VW'(i);
            end
        end
    end

    // advance computation
    logic        sel_ok;
    logic [VW-1:0] sel_ix;
    logic [24:0] pos_sum;
    logic [23:0] pos_sat;
    logic [24:0] pos_end;
    logic        adv_act, adv_rel;
    logic [15:0] adv_fade;
    logic [23:0] adv_pos;
    assign sel_ok  = ({28'd0, r_sel} < 32'(VOICES));
    assign sel_ix  = r_sel[VW-1:0];
    assign pos_sum = {1'b0, rd_pos} + {9'd0, r_consumed};
    assign pos_sat = pos_sum[24] ? PosMax : pos_sum[23:0];
    assign pos_end = {1'b0, pos_sat} + {1'b0, EndGuard};

    always_comb begin
        adv_act  = r_active[sel_ix];
        adv_rel  = r_releasing[sel_ix];
        adv_fade = r_written[sel_ix] ? rd_fade : 16'd0;
        adv_pos  = rd_pos;
        if (adv_act && r_cache_ready) begin
            if (rd_pos < r_sample_len) begin
                if (adv_rel && r_block_len != 13'd0) begin
                    if (rd_fade <= {3'd0, r_block_len}) begin
                        adv_fade = 16'd0;
                        adv_act  = 1'b0;
                    end else begin
                        adv_fade = rd_fade - {3'd0, r_block_len};
                    end
                end
                adv_pos = pos_sat;
                if (r_consumed == 16'd0 && pos_end >= {1'b0, r_sample_len}) begin
                    adv_act = 1'b0;
                end
            end else begin
                adv_act = 1'b0;
            end
        end
    end

    logic [3:0] semi_idx;
    always_comb begin
        if ({1'b0, r_key} + 8'd6 <= {1'b0, r_root}) begin
            semi_idx = 4'd0;
        end else if ({1'b0, r_key} >= {1'b0, r_root} + 8'd6) begin
            semi_idx = 4'd12;
        end else begin
            semi_idx = 4'(r_key + 7'd6 - r_root);
        end
    end

    // in S_OUT, result register loads once it is empty or being drained
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // note-off: a matching voice gets its fade loaded through the single write port
    logic [VW-1:0] off_ix;
    logic          off_hit;
    assign off_ix  = VW'(r_cmp - 1'b1);
    assign off_hit = (r_state == S_SCAN) && (r_op == OP_NOTE_OFF) && (r_cmp != '0)
                     && r_active[off_ix] && !r_releasing[off_ix] && (rd_key == r_key);

    logic          wr_off;
    assign wr_off = off_hit;

    logic [VW-1:0] cmp_ix;
    assign cmp_ix = off_ix;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pick;
        mem_wdata = {r_key, r_root, 24'd0, 16'd0};
        mem_raddr = r_cnt[VW-1:0];
        if (r_state == S_ARD) begin
            mem_raddr = sel_ix;
        end
        if (r_state == S_PICK && r_op == OP_NOTE_ON) begin
            mem_we = 1'b1;
        end else if (r_state == S_AWR && sel_ok) begin
            mem_we    = 1'b1;
            mem_waddr = sel_ix;
            mem_wdata = {rd_key, mem_rdata[46:40], adv_pos, adv_fade};
        end else if (off_hit) begin
            // scan reads one entry ahead, so this write never meets the read
            mem_we    = 1'b1;
            mem_waddr = off_ix;
            mem_wdata = {rd_key, mem_rdata[46:40], rd_pos, r_release_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_releasing <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op        <= t_op'(s_axis_tdata[1:0]);
                        r_key       <= s_axis_tdata[8:2];
                        r_sel       <= s_axis_tdata[12:9];
                        r_consumed  <= s_axis_tdata[28:13];
                        r_block_len <= s_axis_tdata[41:29];
                        r_lower     <= {1'b0, r_lowest};
                        r_cnt       <= '0;
                        r_cmp       <= '0;
                        r_mask      <= '0;
                        r_best_pos  <= '0;
                        r_pick      <= '0;
                        r_res       <= '0;
                        unique case (t_op'(s_axis_tdata[1:0]))
                            OP_NOTE_ON: begin
                                if (r_cache_ready) r_state <= S_ROOT;
                                else               r_state <= S_OUT;
                            end
                            OP_NOTE_OFF: r_state <= S_SCAN;
                            OP_ADVANCE:  r_state <= S_ARD;
                            default:     r_state <= S_OUT;
                        endcase
                    end
                end
                S_ROOT: begin
                    if (step_ok) begin
                        r_lower <= nxt;
                    end else begin
                        if ({1'b0, r_key} <= r_lower) begin
                            r_root <= r_lower[6:0];
                        end else if (nxt > cap) begin
                            r_root <= r_lower[6:0];
                        end else if (({1'b0, r_key} - r_lower) < (nxt - {1'b0, r_key})) begin
                            r_root <= r_lower[6:0];
                        end else begin
                            r_root <= nxt[6:0];
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read address r_cnt, data for r_cmp-1 on port
                    r_cnt <= r_cnt + 1'b1;
                    r_cmp <= r_cnt + 1'b1;
                    if (r_op == OP_NOTE_OFF) begin
                        if (wr_off) begin
                            r_releasing[cmp_ix] <= 1'b1;
                            r_mask[cmp_ix]      <= 1'b1;
                        end
                    end else if (r_cmp != '0) begin
                        // an idle voice wins over the furthest one
                        if (r_cmp == CW'(VOICES) && any_idle) begin
                            r_pick <= first_idle;
                        end else if (rd_pos > r_best_pos) begin
                            r_best_pos <= rd_pos;
                            r_pick     <= cmp_ix;
                        end
                    end
                    if (r_cmp == CW'(VOICES)) begin
                        if (r_op != OP_NOTE_OFF) begin
                            r_stolen <= !any_idle;
                        end
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_op == OP_NOTE_ON) begin
                        r_active[r_pick]    <= 1'b1;
                        r_releasing[r_pick] <= 1'b0;
                        r_written[r_pick]   <= 1'b1;
                        r_res[0]     <= 1'b1;
                        r_res[4:1]   <= 4'(r_pick);
                        r_res[5]     <= r_stolen;
                        r_res[12:6]  <= r_root;
                        r_res[27:13] <= pitch_lookup(semi_idx);
                    end else begin
                        r_res[43:28] <= 16'(r_mask);
                    end
                    r_state <= S_OUT;
                end
                S_ARD: begin
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    if (sel_ok) begin
                        r_active[sel_ix] <= adv_act;
                        r_res[44]    <= adv_act;
                        r_res[60:45] <= adv_fade;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait here while the previous result is still held
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // assertions
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_rel_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_op == OP_NOTE_ON) |=> r_active[$past(r_pick)])
        else $error("allocated voice not active");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
